// ===== hw/rtl/swrr_pkg.sv =====
// Package for the sliding-window reorder receiver.
// Holds widths, codes and the queue entry types shared by front and back ends.
package swrr_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int HANDLE_BITS  = 16;
   localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
   localparam int CMDQ_DEPTH   = 2;
   localparam int RSPQ_DEPTH   = 4;
   localparam logic [15:0] IDLE_TICKS_RESET = 16'd1000;

   typedef enum logic [1:0] {
      FUNC_ARRIVE = 2'd0,
      FUNC_DONE   = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_STORED   = 3'd0,
      KIND_DROPPED  = 3'd1,
      KIND_REACK    = 3'd2,
      KIND_DISPATCH = 3'd3,
      KIND_RELEASED = 3'd4
   } kind_type;

   localparam logic [1:0] DONE_OK      = 2'd0;
   localparam logic [1:0] DONE_WM_ERR  = 2'd1;
   localparam logic [1:0] DONE_SYNC    = 2'd2;

   // Request as it leaves the front end.
   typedef struct packed {
      func_type    func;
      logic [31:0] session_id;
      logic [31:0] sequence_req;
      logic [63:0] packet_id;
      logic        is_last;
      logic [15:0] msg_handle;
      logic [1:0]  done_status;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] handle;
      logic [31:0] seq_out;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_POST_CLEAR,
      ST_DISPATCH,
      ST_STORE
   } state_type;

endpackage

// ===== hw/rtl/swrr_front.sv =====
// Front end of the reorder receiver: accepts requests into a short queue.
// Depends on swrr_pkg.
module swrr_front
   import swrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  cmd_type cmd_in,
   input  logic    take,
   output logic    avail,
   output cmd_type cmd_out
);

   localparam int PTR_BITS = $clog2(CMDQ_DEPTH);

   cmd_type             mem_ff [CMDQ_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_BITS:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == (PTR_BITS+1)'(CMDQ_DEPTH));
   assign avail   = (cnt_ff != '0);
   assign cmd_out = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = take && avail;

   always_comb begin
      wr_in  = do_push ? PTR_BITS'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? PTR_BITS'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/swrr_back.sv =====
// Back end of the reorder receiver: window state, slot store and sequencer.
// Depends on swrr_pkg.
module swrr_back
   import swrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] idle_ticks,
   input  logic        avail,
   input  cmd_type     cmd,
   output logic        take,
   output logic        out_valid,
   output rsp_type     out_rsp,
   input  logic        out_room
);

   state_type state_ff, state_in;

   logic [31:0] cur_session_ff, finished_seq_ff, working_seq_ff, end_seq_ff;
   logic [63:0] finished_packet_ff, working_packet_ff;
   logic        mark_err_ff, timer_armed_ff;
   logic [15:0] idle_count_ff;
   logic [WINDOW_DEPTH-1:0] slot_valid_ff;
   logic [HANDLE_BITS-1:0]  slot_handle_ff [WINDOW_DEPTH];
   logic [63:0]             slot_packet_ff [WINDOW_DEPTH];
   logic [31:0]             slot_seq_ff    [WINDOW_DEPTH];

   cmd_type     cmd_ff;
   logic        store_after_ff; // after clear: store (1) or drop (0)

   // Decoded views
   logic [SLOT_BITS-1:0] in_slot, nx_slot;
   logic [31:0] next_seq;
   logic        can_disp;
   logic [32:0] seq_diff;
   logic        new_sess;
   logic        clear_any;
   logic [SLOT_BITS-1:0] first_valid;
   logic [15:0] idle_inc;
   logic        last_valid;
   cmd_type     cur_cmd;
   logic        disp_follows;

   assign in_slot  = cmd.sequence_req[SLOT_BITS-1:0];
   assign next_seq = finished_seq_ff + 32'd1;
   assign nx_slot  = next_seq[SLOT_BITS-1:0];
   assign can_disp = (working_seq_ff == '0) && (finished_seq_ff != '1) &&
                     slot_valid_ff[nx_slot] && (slot_seq_ff[nx_slot] == next_seq);
   assign seq_diff = {1'b0, cmd.sequence_req} - {1'b0, finished_seq_ff};
   assign new_sess = (cmd.session_id != cur_session_ff);
   assign clear_any = (slot_valid_ff != '0);
   assign idle_inc = (idle_count_ff != 16'hFFFF) ? idle_count_ff + 16'd1 : idle_count_ff;
   assign cur_cmd  = (state_ff == ST_IDLE) ? cmd : cmd_ff;
   // a dispatch or release follows the store when the stored one is next in line or one is ready
   assign disp_follows = (working_seq_ff == '0) && (finished_seq_ff != '1) &&
                         ((cur_cmd.sequence_req == next_seq) || can_disp);

   always_comb begin
      first_valid = '0;
      for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
         if (slot_valid_ff[i]) first_valid = SLOT_BITS'(i);
      end
   end

   // set when the lowest valid slot is the only valid one, or when no slot is valid
   always_comb begin
      last_valid = 1'b1;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (slot_valid_ff[i] && SLOT_BITS'(i) != first_valid) last_valid = 1'b0;
      end
   end

   // Single-step decision from current state
   typedef enum logic [3:0] {
      ACT_NONE, ACT_TAKE_QUIET, ACT_EMIT_DROP, ACT_EMIT_REACK, ACT_START_CLEAR,
      ACT_RELEASE_DUP, ACT_STORE, ACT_CLEAR_STEP, ACT_DISPATCH, ACT_DISP_REL,
      ACT_DONE_OK, ACT_TICK
   } act_type;

   act_type act;
   logic    emit_v;
   rsp_type emit_r;

   always_comb begin
      act    = ACT_NONE;
      emit_v = 1'b0;
      emit_r = '{kind: KIND_DROPPED, handle: cmd.msg_handle, seq_out: cmd.sequence_req,
                 last_of_run: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            if (avail && out_room) begin
               case (cmd.func)
                  FUNC_ARRIVE: begin
                     if (working_seq_ff != '0 && cur_session_ff != '0) begin
                        act = ACT_EMIT_DROP; emit_v = 1'b1;
                     end else if (new_sess) begin
                        act = ACT_START_CLEAR;
                     end else if (cmd.sequence_req <= finished_seq_ff) begin
                        act = ACT_EMIT_REACK; emit_v = 1'b1;
                        emit_r.kind = KIND_REACK;
                     end else if (cmd.sequence_req == working_seq_ff ||
                                  (end_seq_ff != '0 && cmd.sequence_req > end_seq_ff) ||
                                  (cmd.packet_id != '0 &&
                                   cmd.packet_id < finished_packet_ff) ||
                                  (mark_err_ff && cmd.sequence_req != 32'd1) ||
                                  seq_diff > 33'(WINDOW_DEPTH) ||
                                  (slot_valid_ff[in_slot] &&
                                   slot_packet_ff[in_slot] > cmd.packet_id)) begin
                        act = ACT_EMIT_DROP; emit_v = 1'b1;
                     end else if (slot_valid_ff[in_slot]) begin
                        act = ACT_RELEASE_DUP; emit_v = 1'b1;
                        emit_r = '{kind: KIND_RELEASED,
                                   handle: 16'(slot_handle_ff[in_slot]),
                                   seq_out: slot_seq_ff[in_slot], last_of_run: 1'b0};
                     end else begin
                        act = ACT_STORE;
                     end
                  end
                  FUNC_DONE: begin
                     if (working_seq_ff == '0) act = ACT_TAKE_QUIET;
                     else if (cmd.done_status == DONE_WM_ERR ||
                              cmd.done_status == DONE_SYNC) act = ACT_START_CLEAR;
                     else act = ACT_DONE_OK;
                  end
                  FUNC_TICK: begin
                     if (!timer_armed_ff) act = ACT_TAKE_QUIET;
                     else act = ACT_TICK;
                  end
                  default: act = ACT_TAKE_QUIET;
               endcase
            end
         end
         ST_STORE: begin
            if (out_room) begin
               act = ACT_STORE;
            end
         end
         ST_CLEAR: begin
            if (out_room) begin
               if (clear_any) begin
                  act = ACT_CLEAR_STEP; emit_v = 1'b1;
                  emit_r = '{kind: KIND_RELEASED,
                             handle: 16'(slot_handle_ff[first_valid]),
                             seq_out: slot_seq_ff[first_valid],
                             last_of_run: last_valid &&
                                          !(cmd_ff.func == FUNC_ARRIVE)};
               end else begin
                  act = ACT_CLEAR_STEP;
               end
            end
         end
         ST_DISPATCH: begin
            if (out_room) begin
               if (can_disp) begin
                  emit_v = 1'b1;
                  if (slot_packet_ff[nx_slot] != '0 &&
                      slot_packet_ff[nx_slot] < finished_packet_ff) begin
                     act = ACT_DISP_REL;
                     emit_r.kind = KIND_RELEASED;
                  end else begin
                     act = ACT_DISPATCH;
                     emit_r.kind = KIND_DISPATCH;
                  end
                  emit_r.handle  = 16'(slot_handle_ff[nx_slot]);
                  emit_r.seq_out = next_seq;
                  emit_r.last_of_run = 1'b1;
               end else begin
                  act = ACT_DISPATCH;
               end
            end
         end
         default: act = ACT_NONE;
      endcase
   end

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      case (act)
         ACT_START_CLEAR: state_in = ST_CLEAR;
         ACT_RELEASE_DUP: state_in = ST_STORE;
         ACT_STORE:       state_in = ST_DISPATCH;
         ACT_DONE_OK:     state_in = ST_DISPATCH;
         ACT_TICK:        state_in = (idle_inc >= idle_ticks) ? ST_CLEAR : ST_IDLE;
         ACT_CLEAR_STEP: begin
            if (!clear_any || last_valid) begin
               if (cmd_ff.func == FUNC_ARRIVE) state_in = ST_POST_CLEAR;
               else state_in = ST_IDLE;
            end
         end
         ACT_DISPATCH, ACT_DISP_REL: state_in = ST_IDLE;
         default: state_in = state_ff;
      endcase
      if (state_ff == ST_POST_CLEAR) state_in = store_after_ff ? ST_STORE : ST_POST_CLEAR;
      if (state_ff == ST_POST_CLEAR && !store_after_ff && out_room) state_in = ST_IDLE;
   end

   // Take from the command queue once the request is latched
   assign take = (act == ACT_EMIT_DROP) || (act == ACT_EMIT_REACK) ||
                 (act == ACT_TAKE_QUIET) || (act == ACT_START_CLEAR) ||
                 (act == ACT_RELEASE_DUP) || (state_ff == ST_IDLE && act == ACT_STORE) ||
                 (act == ACT_DONE_OK) || (act == ACT_TICK);

   // Store-stage emit and post-clear drop are handled here
   always_comb begin
      out_valid = emit_v;
      out_rsp   = emit_r;
      if (act == ACT_STORE) begin
         out_valid = 1'b1;
         out_rsp = '{kind: KIND_STORED, handle: cur_cmd.msg_handle,
                     seq_out: cur_cmd.sequence_req, last_of_run: !disp_follows};
      end
      if (state_ff == ST_POST_CLEAR && !store_after_ff && out_room) begin
         out_valid = 1'b1;
         out_rsp = '{kind: KIND_DROPPED, handle: cmd_ff.msg_handle,
                     seq_out: cmd_ff.sequence_req, last_of_run: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         cur_session_ff     <= '0;
         finished_seq_ff    <= '0;
         finished_packet_ff <= '0;
         working_seq_ff     <= '0;
         working_packet_ff  <= '0;
         end_seq_ff         <= '0;
         mark_err_ff        <= 1'b0;
         timer_armed_ff     <= 1'b0;
         idle_count_ff      <= '0;
         slot_valid_ff      <= '0;
         store_after_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (act)
            ACT_START_CLEAR: begin
               if (cmd.func == FUNC_ARRIVE) begin
                  finished_seq_ff    <= '0;
                  finished_packet_ff <= '0;
                  working_seq_ff     <= '0;
                  working_packet_ff  <= '0;
                  end_seq_ff         <= '0;
                  mark_err_ff        <= 1'b0;
                  cur_session_ff     <= cmd.session_id;
                  store_after_ff     <= (cmd.sequence_req != '0) &&
                                        (cmd.sequence_req <= 32'(WINDOW_DEPTH));
               end else begin
                  working_seq_ff  <= '0;
                  finished_seq_ff <= '0;
                  end_seq_ff      <= '0;
                  mark_err_ff     <= 1'b1;
               end
            end
            ACT_RELEASE_DUP: begin
               slot_valid_ff[in_slot] <= 1'b0;
               if (cmd.sequence_req == 32'd1) mark_err_ff <= 1'b0;
            end
            ACT_STORE: begin
               if (state_ff == ST_IDLE && cur_cmd.sequence_req == 32'd1) mark_err_ff <= 1'b0;
               slot_valid_ff[cur_cmd.sequence_req[SLOT_BITS-1:0]] <= 1'b1;
               if (cur_cmd.is_last) end_seq_ff <= cur_cmd.sequence_req;
               idle_count_ff  <= '0;
               timer_armed_ff <= 1'b1;
            end
            ACT_CLEAR_STEP: begin
               if (clear_any) slot_valid_ff[first_valid] <= 1'b0;
            end
            ACT_DISPATCH: begin
               if (can_disp) begin
                  slot_valid_ff[nx_slot] <= 1'b0;
                  working_seq_ff    <= next_seq;
                  working_packet_ff <= slot_packet_ff[nx_slot];
               end
            end
            ACT_DISP_REL: slot_valid_ff[nx_slot] <= 1'b0;
            ACT_DONE_OK: begin
               working_seq_ff     <= '0;
               finished_seq_ff    <= next_seq;
               finished_packet_ff <= working_packet_ff;
            end
            ACT_TICK: begin
               if (idle_inc >= idle_ticks) begin
                  timer_armed_ff <= 1'b0;
                  idle_count_ff  <= '0;
               end else begin
                  idle_count_ff <= idle_inc;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take) cmd_ff <= cmd;
      if (act == ACT_STORE) begin
         slot_handle_ff[cur_cmd.sequence_req[SLOT_BITS-1:0]] <=
            HANDLE_BITS'(cur_cmd.msg_handle);
         slot_packet_ff[cur_cmd.sequence_req[SLOT_BITS-1:0]] <= cur_cmd.packet_id;
         slot_seq_ff[cur_cmd.sequence_req[SLOT_BITS-1:0]]    <= cur_cmd.sequence_req;
      end
   end

`ifndef SYNTHESIS
   a_no_disp_while_busy: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_DISPATCH && can_disp) |-> (working_seq_ff == '0))
      else $error("dispatch while outstanding");
   a_take_idle_only: assert property (@(posedge clock) disable iff (reset)
      take |-> (state_ff == ST_IDLE))
      else $error("take outside idle");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_room)
      else $error("result without room");
`endif

endmodule

// ===== hw/rtl/sliding_window_reorder_receiver_unit.sv =====
// Top level of the sliding-window reorder receiver.
// Depends on swrr_pkg, swrr_front, swrr_back.
//
//  channel | ports                 | handshake
//  request | req_*                 | push / full
//  result  | rsp_*                 | pop / empty
//  config  | csr_wr_en, csr_wr_data| write enable, no wait
//
// A request is registered in the front queue, then the back end gives its results one
// after another, with a dispatch check after a store or an ok completion.
// A window clear starts, then releases the stored messages in turn, and passes a
// post-clear step before a new session's message. Reset clears all control state;
// slot contents stay undefined until written. The back end stalls while the result
// queue holds three results.
module sliding_window_reorder_receiver_unit
   import swrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_session_id,
   input  logic [31:0] req_sequence_req,
   input  logic [63:0] req_packet_id,
   input  logic        req_is_last,
   input  logic [15:0] req_msg_handle,
   input  logic [1:0]  req_done_status,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_handle,
   output logic [31:0] rsp_seq_out,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] idle_ticks_ff;
   cmd_type     cmd_in, cmd_q;
   logic        avail, take, b_valid, room;
   rsp_type     b_rsp;

   always_ff @(posedge clock) begin
      if (reset) idle_ticks_ff <= IDLE_TICKS_RESET;
      else if (csr_wr_en) idle_ticks_ff <= (csr_wr_data == '0) ? 16'd1 : csr_wr_data;
   end

   assign cmd_in = '{func: func_type'(req_func), session_id: req_session_id,
                     sequence_req: req_sequence_req, packet_id: req_packet_id,
                     is_last: req_is_last, msg_handle: req_msg_handle,
                     done_status: req_done_status};

   swrr_front u_front (
      .clock, .reset, .push, .full, .cmd_in,
      .take, .avail, .cmd_out(cmd_q)
   );

   swrr_back u_back (
      .clock, .reset, .idle_ticks(idle_ticks_ff), .avail, .cmd(cmd_q), .take,
      .out_valid(b_valid), .out_rsp(b_rsp), .out_room(room)
   );

   // Result queue
   localparam int RP = $clog2(RSPQ_DEPTH);
   rsp_type      rq_ff [RSPQ_DEPTH];
   logic [RP-1:0] rw_ff, rr_ff;
   logic [RP:0]   rc_ff;
   logic          do_w, do_r;

   assign room  = (rc_ff < (RP+1)'(RSPQ_DEPTH - 1));
   assign do_w  = b_valid;
   assign do_r  = pop && !empty;
   assign empty = (rc_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff <= '0; rr_ff <= '0; rc_ff <= '0;
      end else begin
         if (do_w) rw_ff <= RP'(rw_ff + 1'b1);
         if (do_r) rr_ff <= RP'(rr_ff + 1'b1);
         rc_ff <= rc_ff + (RP+1)'(do_w) - (RP+1)'(do_r);
      end
   end

   always_ff @(posedge clock) begin
      if (do_w) begin
         rq_ff[rw_ff] <= b_rsp;
      end
   end

   assign rsp_kind        = rq_ff[rr_ff].kind;
   assign rsp_handle      = rq_ff[rr_ff].handle;
   assign rsp_seq_out     = rq_ff[rr_ff].seq_out;
   assign rsp_last_of_run = rq_ff[rr_ff].last_of_run;

endmodule
